// ===== rtl/sha1md_pkg.sv =====
// Shared types, constants and helper functions of the SHA-1 message digest block.
package sha1md_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0]  byte_t;

    // Initial chaining values, element 0 is word A.
    localparam logic [4:0][31:0] SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam word_t K_R0 = 32'h5A827999;
    localparam word_t K_R1 = 32'h6ED9EBA1;
    localparam word_t K_R2 = 32'h8F1BBCDC;
    localparam word_t K_R3 = 32'hCA62C1D6;

    localparam byte_t PAD_BYTE     = 8'h80;
    localparam byte_t ZERO_BYTE    = 8'h00;
    localparam int    NUM_ROUNDS   = 80;
    localparam int    DIGEST_WORDS = 5;
    localparam logic [5:0] LEN_START = 6'd56;

    // Commands from the sequencer to the compression unit.
    typedef struct packed {
        logic start;
        logic reinit;
    } cmp_cmd_t;

    // Status of the compression unit.
    typedef struct packed {
        logic busy;
        logic done;
    } cmp_sts_t;

    function automatic word_t rotl1(input word_t x);
        return {x[30:0], x[31]};
    endfunction

    function automatic word_t rotl5(input word_t x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic word_t rotl30(input word_t x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

// ===== rtl/sha1md_msg_if.sv =====
// Input channel interface: one message byte with its framing flags per transaction.
interface sha1md_msg_if
    import sha1md_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  byte_present;
    logic  message_end;

    modport source (output valid, output data_byte, output byte_present,
                    output message_end, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input message_end, output ready);
endinterface

// ===== rtl/sha1md_digest_if.sv =====
// Output channel interface: one digest word with its position per transaction.
interface sha1md_digest_if
    import sha1md_pkg::*;
();
    logic       valid;
    logic       ready;
    word_t      digest_word;
    logic [2:0] word_index;
    logic       final_word;

    modport source (output valid, output digest_word, output word_index,
                    output final_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input final_word, output ready);
endinterface

// ===== rtl/sha1md_compress.sv =====
// SHA-1 compression unit: chaining words, working variables and rolling schedule.
module sha1md_compress
    import sha1md_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmp_cmd_t         cmd,
    output cmp_sts_t         sts,
    output logic [3:0]       rd_addr,
    input  word_t            rd_data,
    output logic [4:0][31:0] chain
);

    logic [4:0][31:0]  chain_reg, chain_next;
    logic [4:0][31:0]  rr_reg, rr_next;
    logic [15:0][31:0] sched_reg, sched_next;
    logic [6:0]        rnd_reg, rnd_next;
    logic              busy_reg, busy_next;
    logic              fold_reg, fold_next;

    word_t w, f, k, t;

    // The first sixteen rounds take the block words from memory, the rest
    // are expanded from the sixteen words held in the shift line.
    always_comb
    begin
        if (rnd_reg < 7'd16)
        begin
            w = rd_data;
        end
        else
        begin
            w = rotl1(sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0]);
        end

        priority if (rnd_reg < 7'd20)
        begin
            f = (rr_reg[1] & rr_reg[2]) | (~rr_reg[1] & rr_reg[3]);
            k = K_R0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = rr_reg[1] ^ rr_reg[2] ^ rr_reg[3];
            k = K_R1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (rr_reg[1] & rr_reg[2]) | (rr_reg[1] & rr_reg[3]) | (rr_reg[2] & rr_reg[3]);
            k = K_R2;
        end
        else
        begin
            f = rr_reg[1] ^ rr_reg[2] ^ rr_reg[3];
            k = K_R3;
        end

        t = rotl5(rr_reg[0]) + f + rr_reg[4] + k + w;
    end

    always_comb
    begin
        chain_next = chain_reg;
        rr_next    = rr_reg;
        sched_next = sched_reg;
        rnd_next   = rnd_reg;
        busy_next  = busy_reg;
        fold_next  = 1'b0;

        if (cmd.start)
        begin
            rr_next   = chain_reg;
            rnd_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rr_next    = {rr_reg[3], rr_reg[2], rotl30(rr_reg[1]), rr_reg[0], t};
            sched_next = {w, sched_reg[15:1]};
            rnd_next   = rnd_reg + 7'd1;
            if (rnd_reg == 7'(NUM_ROUNDS - 1))
            begin
                busy_next = 1'b0;
                fold_next = 1'b1;
            end
        end

        if (fold_reg)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_next[i] = chain_reg[i] + rr_reg[i];
            end
        end

        if (cmd.reinit)
        begin
            chain_next = SHA1_IV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= SHA1_IV;
            rnd_reg   <= '0;
            busy_reg  <= 1'b0;
            fold_reg  <= 1'b0;
        end
        else
        begin
            chain_reg <= chain_next;
            rnd_reg   <= rnd_next;
            busy_reg  <= busy_next;
            fold_reg  <= fold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg    <= rr_next;
        sched_reg <= sched_next;
    end

    // The read for round i+1 is issued during round i; the start cycle fetches word 0.
    assign rd_addr  = busy_reg ? 4'(rnd_reg[3:0] + 4'd1) : 4'd0;
    assign sts.busy = busy_reg;
    assign sts.done = fold_reg;
    assign chain    = chain_reg;

endmodule

// ===== rtl/sha1_message_digest.sv =====
// Top level of the SHA-1 message digest: byte sequencer, block memory and digest output.
//
//  Channel  Role  Transaction carries
//  -------  ----  ---------------------------------------------------------
//  msg      sink  data_byte, byte_present, message_end (one message byte)
//  digest   src   digest_word, word_index, final_word (one 32-bit digest word)
//
// An ordinary byte is appended while the sequencer is idle. A byte that
// completes a 64-byte block starts the compression unit, which runs one
// round per cycle: 80 rounds and then a fold of the result into the
// chaining words. The end of a message pads one byte per cycle, except while
// a compression runs, through the same path as message bytes, with a step
// between the zeros and the length field, runs one or two compressions and
// then hands out the five digest words, one per cycle when
// the sink is ready. Reset is asynchronous and restores the initial chaining
// words; the block memory is not cleared, as every word is written before it
// is read. A stalled digest sink holds the output register, and input
// transactions are accepted again as soon as the last word has been loaded.
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sha1md_msg_if.sink      msg,
    sha1md_digest_if.source digest
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_PADLEN,
        S_COMP,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [5:0]  bytes_reg, bytes_next;
    logic [63:0] bits_reg, bits_next;
    logic [23:0] word_reg, word_next;
    logic [2:0]  idx_reg, idx_next;

    logic        out_valid_reg, out_valid_next;
    word_t       out_word_reg, out_word_next;
    logic [2:0]  out_index_reg, out_index_next;
    logic        out_final_reg, out_final_next;

    // Append path: one byte per cycle, except while a compression runs, into the word assembly register.
    logic        app_en;
    byte_t       app_byte;
    logic        block_full;
    logic        out_load;

    // Block memory: sixteen 32-bit words, written one word at a time.
    word_t       blk_mem [16];
    word_t       rd_data_reg;
    logic [3:0]  rd_addr;
    logic        mem_we;

    cmp_cmd_t         cmp_cmd;
    cmp_sts_t         cmp_sts;
    logic [4:0][31:0] chain;

    sha1md_compress u_compress (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmp_cmd),
        .sts     (cmp_sts),
        .rd_addr (rd_addr),
        .rd_data (rd_data_reg),
        .chain   (chain)
    );

    assign block_full = app_en && (bytes_reg == 6'd63);
    assign mem_we     = app_en && (bytes_reg[1:0] == 2'b11);
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || digest.ready);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            blk_mem[bytes_reg[5:2]] <= {word_reg, app_byte};
        end
        rd_data_reg <= blk_mem[rd_addr];
        word_reg    <= word_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        bytes_next     = bytes_reg;
        bits_next      = bits_reg;
        idx_next       = idx_reg;
        app_en         = 1'b0;
        app_byte       = ZERO_BYTE;
        cmp_cmd        = '0;
        msg.ready      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    if (msg.byte_present)
                    begin
                        app_en    = 1'b1;
                        app_byte  = msg.data_byte;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (block_full)
                    begin
                        state_next = S_COMP;
                        ret_next   = msg.message_end ? S_PAD80 : S_IDLE;
                    end
                    else if (msg.message_end)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end

            S_PAD80:
            begin
                app_en     = 1'b1;
                app_byte   = PAD_BYTE;
                state_next = S_PADZ;
                if (block_full)
                begin
                    state_next = S_COMP;
                    ret_next   = S_PADZ;
                end
            end

            S_PADZ:
            begin
                if (bytes_reg == LEN_START)
                begin
                    state_next = S_PADLEN;
                end
                else
                begin
                    app_en = 1'b1;
                    if (block_full)
                    begin
                        state_next = S_COMP;
                        ret_next   = S_PADZ;
                    end
                end
            end

            // The length goes out most significant byte first; the counter
            // shifts as it goes and is cleared once the last digest word is loaded.
            S_PADLEN:
            begin
                app_en    = 1'b1;
                app_byte  = bits_reg[63:56];
                bits_next = {bits_reg[55:0], ZERO_BYTE};
                if (block_full)
                begin
                    state_next = S_COMP;
                    ret_next   = S_OUT;
                end
            end

            S_COMP:
            begin
                if (cmp_sts.done)
                begin
                    state_next = ret_reg;
                end
            end

            S_OUT:
            begin
                if (out_load)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(DIGEST_WORDS - 1))
                    begin
                        idx_next       = '0;
                        bits_next      = '0;
                        cmp_cmd.reinit = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        cmp_cmd.start = block_full;
        if (app_en)
        begin
            bytes_next = bytes_reg + 6'd1;
        end
    end

    assign word_next = app_en ? {word_reg[15:0], app_byte} : word_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_final_next = out_final_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_word_next  = chain[idx_reg];
            out_index_next = idx_reg;
            out_final_next = (idx_reg == 3'(DIGEST_WORDS - 1));
        end
        else if (digest.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            bytes_reg     <= '0;
            bits_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            out_index_reg <= '0;
            out_final_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            bytes_reg     <= bytes_next;
            bits_reg      <= bits_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
            out_index_reg <= out_index_next;
            out_final_reg <= out_final_next;
        end
    end

    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = out_index_reg;
    assign digest.final_word  = out_final_reg;

    // Input transactions must never overlap a running compression.
    a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        msg.ready |-> !cmp_sts.busy)
        else $error("input accepted while compression is running");

    // A compression starts only on the byte that closes a block.
    a_start_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_cmd.start |=> (bytes_reg == 6'd0))
        else $error("compression started without a full block");

    // Folding into the chaining words only happens while the sequencer waits for it.
    a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_sts.done |-> (state_reg == S_COMP))
        else $error("compression finished outside the compression state");

    // The length field always begins at byte 56 of a block.
    a_len_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PADZ && state_next == S_PADLEN) |-> (bytes_reg == LEN_START))
        else $error("length field misaligned");

    // Loading the last digest word re-initialises the chaining words.
    a_last_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && idx_reg == 3'(DIGEST_WORDS - 1)) |=> (state_reg == S_IDLE
            && digest.valid && digest.final_word))
        else $error("digest did not end on its final word");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the SHA-1 message digest block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1md_pkg::*;

    // Initial chaining words and round constants of SHA-1, held locally so that
    // the prediction below stands apart from the design's package.
    localparam word_t H0 = 32'h67452301;
    localparam word_t H1 = 32'hEFCDAB89;
    localparam word_t H2 = 32'h98BADCFE;
    localparam word_t H3 = 32'h10325476;
    localparam word_t H4 = 32'hC3D2E1F0;
    localparam word_t ROUND_K0 = 32'h5A827999;
    localparam word_t ROUND_K1 = 32'h6ED9EBA1;
    localparam word_t ROUND_K2 = 32'h8F1BBCDC;
    localparam word_t ROUND_K3 = 32'hCA62C1D6;
    localparam byte_t MARKER_BYTE = 8'h80;

    // Least number of transactions that carry a byte or end a message in each
    // idling phase of the random traffic; the last message may go beyond it.
    localparam int PHASE_ITEMS = 4;
    // Cycles allowed after the last expected digest word for stray output.
    localparam int SETTLE_CYCLES = 250;

    // One expected digest word, in the order in which the block hands them out.
    typedef struct {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_beat_t;

    logic clk;
    logic rst_n;

    sha1md_msg_if    msg_ch();
    sha1md_digest_if digest_ch();

    sha1_message_digest uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (digest_ch)
    );

    // Percentages of cycles in which the sender holds back and the receiver
    // refuses a transaction. They are changed between the phases of the run.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int failures       = 0;
    int items_sent     = 0;

    // Predicted state of the hashing engine: chaining words, partly filled
    // block, fill level and running message length in bits.
    word_t       chain[5];
    byte_t       block_buf[64];
    int unsigned block_fill;
    logic [63:0] msg_bits;

    digest_beat_t expected_words[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic word_t rol(input word_t x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_chain();
        chain[0]   = H0;
        chain[1]   = H1;
        chain[2]   = H2;
        chain[3]   = H3;
        chain[4]   = H4;
        block_fill = 0;
        msg_bits   = '0;
    endfunction

    // The 80-round compression of the buffered block into the chaining words.
    // The message schedule is kept as a rolling window of sixteen words.
    function automatic void compress_block();
        word_t sched[16];
        word_t a, b, c, d, e, f, k, t, mix;
        int    i;
        for (i = 0; i < 16; i++)
        begin
            sched[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (i = 0; i < 80; i++)
        begin
            if (i >= 16)
            begin
                mix = sched[(i + 13) & 15] ^ sched[(i + 8) & 15]
                    ^ sched[(i + 2) & 15] ^ sched[i & 15];
                sched[i & 15] = rol(mix, 1);
            end
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = ROUND_K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = ROUND_K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = ROUND_K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = ROUND_K3;
            end
            t = rol(a, 5) + f + e + k + sched[i & 15];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void absorb_byte(input byte_t v);
        block_buf[block_fill] = v;
        block_fill++;
        if (block_fill == 64)
        begin
            compress_block();
            block_fill = 0;
        end
    endfunction

    // Updates the predicted state for one accepted input transaction and, at
    // the end of a message, queues the five digest words that must follow.
    // The length field is taken before the padding is added.
    function automatic void predict_digest(input byte_t b, input logic present,
                                           input logic fin);
        logic [63:0]  total;
        digest_beat_t beat;
        int           i;
        if (present)
        begin
            msg_bits += 64'd8;
            absorb_byte(b);
        end
        if (!fin)
        begin
            return;
        end
        total = msg_bits;
        absorb_byte(MARKER_BYTE);
        while (block_fill != 56)
        begin
            absorb_byte(8'h00);
        end
        for (i = 0; i < 8; i++)
        begin
            absorb_byte(total[63 - 8*i -: 8]);
        end
        for (i = 0; i < 5; i++)
        begin
            beat.word  = chain[i];
            beat.index = 3'(i);
            beat.last  = (i == 4);
            expected_words.push_back(beat);
        end
        restart_chain();
    endfunction

    // ------------------------------------------------------------------
    // Digest side: random back-pressure and the comparison of every
    // accepted transaction with the oldest expected word.
    // ------------------------------------------------------------------

    initial
    begin
        digest_beat_t exp_beat;
        digest_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && digest_ch.valid && digest_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("digest_word: none expected, got %h (word_index %0d)",
                           digest_ch.digest_word, digest_ch.word_index);
                    failures++;
                end
                else
                begin
                    exp_beat = expected_words.pop_front();
                    if (digest_ch.digest_word !== exp_beat.word)
                    begin
                        $error("digest_word: expected %h, got %h",
                               exp_beat.word, digest_ch.digest_word);
                        failures++;
                    end
                    if (digest_ch.word_index !== exp_beat.index)
                    begin
                        $error("word_index: expected %0d, got %0d",
                               exp_beat.index, digest_ch.word_index);
                        failures++;
                    end
                    if (digest_ch.final_word !== exp_beat.last)
                    begin
                        $error("final_word: expected %b, got %b",
                               exp_beat.last, digest_ch.final_word);
                        failures++;
                    end
                end
            end
            digest_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Message side
    // ------------------------------------------------------------------

    // Sends one transaction, after a random number of idle cycles, and waits
    // until the block takes it. Valid is left high so that a following
    // transaction can go out back to back.
    task automatic send_item(input byte_t b, input logic present, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid        <= 1'b1;
        msg_ch.data_byte    <= b;
        msg_ch.byte_present <= present;
        msg_ch.message_end  <= fin;
        do
        begin
            @(posedge clk);
        end
        while (!msg_ch.ready);
        predict_digest(b, present, fin);
        if (present || fin)
        begin
            items_sent++;
        end
    endtask

    // Sends a message of random bytes. It ends either on its last byte or
    // with a separate end transaction that carries no byte; transactions
    // that carry nothing at all are scattered in as noise.
    task automatic send_message(input int len, input bit end_on_byte);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(15) == 0)
            begin
                send_item(byte_t'($urandom), 1'b0, 1'b0);
            end
            send_item(byte_t'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0)
        begin
            send_item(byte_t'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Drops valid and holds the sender back until every expected digest word
    // has been taken.
    task automatic wait_for_digests();
        msg_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Two empty messages, each reached by an end transaction with no byte; the
    // first has nothing transactions before it; they must not disturb it.
    task automatic test_empty_message();
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    // Short messages: "abc" ending on its last byte, the extreme byte values
    // ending with an empty end transaction and with a nothing transaction in
    // their middle, and a one-byte message ending on its byte.
    task automatic test_short_messages();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b1);
        send_item(8'hAA, 1'b1, 1'b1);
    endtask

    // Lengths around the block edge: 56 bytes force an extra padding block,
    // and 64 fill a whole block on the byte that also ends the message.
    task automatic test_block_boundaries();
        set_idling(8, 8);
        send_message(56, 1'b0);
        send_message(64, 1'b1);
        wait_for_digests();
    endtask

    // Random short messages in four idling phases. The sender drains the
    // digest queue before each new phase, which also covers a pause with
    // nothing in flight.
    task automatic test_random_traffic();
        int phase;
        int start_count;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(81, 0);
                2: set_idling(0, 81);
                default: set_idling(8, 8);
            endcase
            start_count = items_sent;
            while (items_sent - start_count < PHASE_ITEMS)
            begin
                send_message($urandom_range(0, 8), 1'($urandom_range(1)));
            end
            wait_for_digests();
        end
    endtask

    initial
    begin
        int settle;
        rst_n                 <= 1'b0;
        msg_ch.valid          <= 1'b0;
        msg_ch.data_byte      <= '0;
        msg_ch.byte_present   <= 1'b0;
        msg_ch.message_end    <= 1'b0;
        restart_chain();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_message();
        test_short_messages();
        wait_for_digests();
        test_block_boundaries();
        test_random_traffic();

        // Everything has been sent; wait for the last words, then give any
        // stray output time to show up before the verdict.
        wait_for_digests();
        for (settle = 0; settle < SETTLE_CYCLES; settle++)
        begin
            @(posedge clk);
        end
        if (failures == 0 && expected_words.size() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== sha1_message_digest.f =====
rtl/sha1md_pkg.sv
rtl/sha1md_msg_if.sv
rtl/sha1md_digest_if.sv
rtl/sha1md_compress.sv
rtl/sha1_message_digest.sv
verif/tb.sv
